>>> hw/rtl/mandelbrot_escape_time_pixel_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Mandelbrot escape-time pixel engine.
// Each macro places one labeled concurrent assertion, clocked by clk_i and
// held off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MET_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/met_pkg.sv
// ---------------------------------------------------------------------------
// met_pkg: shared types and constants of the escape-time pixel engine.
// Holds the payload structs, the beat passed between iteration cells, the
// register map, the sine-ramp palette and the Q4.28 saturation helper.
// ---------------------------------------------------------------------------
package met_pkg;

  // Fixed-point and bus widths.
  localparam int COORD_W  = 32;
  localparam int WIDE_W   = 40;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // Image edge in pixels. It is a power of two, so the mapping divides by a shift.
  localparam int IMAGE_SIZE = 512;

  // Number of iteration cells in the ring.
  localparam int NUM_CELLS = 2;

  // Escape radius squared, 4.0 in Q4.28, at the width of the wide sums.
  localparam logic signed [WIDE_W-1:0] FOUR_Q28 = 40'sh0040000000;

  // Color of points that never escape.
  localparam logic [31:0] INSIDE_COLOR = 32'hff00_0000;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

  // Register map, indexed by paddr[3:2].
  localparam logic [1:0] REG_RE_LEFT   = 2'd0;
  localparam logic [1:0] REG_IM_TOP    = 2'd1;
  localparam logic [1:0] REG_RE_RIGHT  = 2'd2;
  localparam logic [1:0] REG_IM_BOTTOM = 2'd3;

  // Reset window: -2.0 .. +2.0 on both axes.
  localparam logic signed [COORD_W-1:0] RST_LOW  = 32'she000_0000;
  localparam logic signed [COORD_W-1:0] RST_HIGH = 32'sh2000_0000;

  // One command beat: the pixel to evaluate.
  typedef struct packed {
    logic [8:0] pixel_x;
    logic [8:0] pixel_y;
  } pixel_t;

  // One result beat.
  typedef struct packed {
    logic [31:0] color;
    logic [8:0]  iterations;
    logic        inside_res;
  } result_t;

  // The point state handed from one iteration cell to the next.
  typedef struct packed {
    logic                      valid;
    logic                      done;
    logic signed [COORD_W-1:0] zr;
    logic signed [COORD_W-1:0] zi;
  } zbeat_t;

  // One period of floor(127 * (1 + sin(2*pi*m/64))).
  localparam logic [7:0] SINE_RAMP [64] = '{
    8'd127, 8'd139, 8'd151, 8'd163, 8'd175, 8'd186, 8'd197, 8'd207,
    8'd216, 8'd225, 8'd232, 8'd239, 8'd244, 8'd248, 8'd251, 8'd253,
    8'd254, 8'd253, 8'd251, 8'd248, 8'd244, 8'd239, 8'd232, 8'd225,
    8'd216, 8'd207, 8'd197, 8'd186, 8'd175, 8'd163, 8'd151, 8'd139,
    8'd127, 8'd114, 8'd102, 8'd90,  8'd78,  8'd67,  8'd56,  8'd46,
    8'd37,  8'd28,  8'd21,  8'd14,  8'd9,   8'd5,   8'd2,   8'd0,
    8'd0,   8'd0,   8'd2,   8'd5,   8'd9,   8'd14,  8'd21,  8'd28,
    8'd37,  8'd46,  8'd56,  8'd67,  8'd78,  8'd90,  8'd102, 8'd114
  };

  // RGB palette entry: the ramp with green and blue shifted by a third
  // and two thirds of a period.
  function automatic logic [23:0] palette_entry(input logic [5:0] k);
    logic [5:0] kg;
    logic [5:0] kb;
    kg = k + 6'd21;
    kb = k + 6'd42;
    return {SINE_RAMP[k], SINE_RAMP[kg], SINE_RAMP[kb]};
  endfunction

  // Clamp a wide signed sum into the 32-bit coordinate range.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -40'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return COORD_W'(v);
    end
  endfunction

endpackage

>>> hw/rtl/met_map.sv
// ---------------------------------------------------------------------------
// met_map: maps one pixel index onto one axis of the complex window.
// Computes lo + floor((hi - lo) * pix / IMAGE_SIZE) in registered steps: the
// exact product first, then an arithmetic shift, the edge and saturation.
// ---------------------------------------------------------------------------
module met_map (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               go_i,
  input  logic signed [met_pkg::COORD_W-1:0] lo_i,
  input  logic signed [met_pkg::COORD_W-1:0] hi_i,
  input  logic [8:0]                         pix_i,
  output logic                               done_o,
  output logic signed [met_pkg::COORD_W-1:0] coord_o
);
  import met_pkg::*;

  // Product of a 33-bit difference and a 9-bit pixel.
  localparam int NumW  = 42;
  localparam int PixSh = $clog2(IMAGE_SIZE);

  logic                      pend_q;
  logic                      done_q;
  logic signed [NumW-1:0]    num_q;
  logic signed [COORD_W-1:0] lo_q;
  logic signed [COORD_W-1:0] coord_q;

  logic signed [32:0]        diff;
  logic signed [NumW:0]      prod;
  logic signed [NumW-1:0]    quot;
  logic signed [WIDE_W-1:0]  sum;

  // Window span times pixel index, exact.
  assign diff = {hi_i[COORD_W-1], hi_i} - {lo_i[COORD_W-1], lo_i};
  assign prod = $signed({{(NumW-32){diff[32]}}, diff}) * $signed({{(NumW-8){1'b0}}, pix_i});

  // The arithmetic shift floors toward minus infinity, then the edge is added.
  assign quot = num_q >>> PixSh;
  assign sum  = {{(WIDE_W-COORD_W){lo_q[COORD_W-1]}}, lo_q} + WIDE_W'(quot);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pend_q <= go_i;
      done_q <= pend_q;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (go_i) begin
      num_q <= prod[NumW-1:0];
      lo_q  <= lo_i;
    end
    if (pend_q) begin
      coord_q <= sat32(sum);
    end
  end

  assign done_o  = done_q;
  assign coord_o = coord_q;

endmodule

>>> hw/rtl/met_cell.sv
// ---------------------------------------------------------------------------
// met_cell: one iteration cell of the escape-time ring.
// The first stage squares and cross-multiplies z; the second tests the
// escape radius and the limit, then forms z*z + c and hands the beat on.
// ---------------------------------------------------------------------------
module met_cell #(
  parameter  int MAX_ITER     = 256,
  parameter  int PALETTE_SIZE = 64,
  localparam int CntW         = $clog2(MAX_ITER + 1),
  localparam int PalW         = $clog2(PALETTE_SIZE)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [met_pkg::COORD_W-1:0] cre_i,
  input  logic signed [met_pkg::COORD_W-1:0] cim_i,
  input  met_pkg::zbeat_t                    beat_i,
  input  logic [CntW-1:0]                    cnt_i,
  input  logic [PalW-1:0]                    pidx_i,
  output met_pkg::zbeat_t                    beat_o,
  output logic [CntW-1:0]                    cnt_o,
  output logic [PalW-1:0]                    pidx_o
);
  import met_pkg::*;

  // Stage A: products.
  logic               a_valid_q;
  logic               a_done_q;
  logic [CntW-1:0]    a_cnt_q;
  logic [PalW-1:0]    a_pidx_q;
  logic signed [63:0] rr_q;
  logic signed [63:0] ii_q;
  logic signed [63:0] ri_q;
  logic signed [63:0] rr_d;
  logic signed [63:0] ii_d;
  logic signed [63:0] ri_d;

  // Stage B: update.
  logic signed [WIDE_W-1:0] xx;
  logic signed [WIDE_W-1:0] yy;
  logic signed [WIDE_W-1:0] xy2;
  logic signed [WIDE_W-1:0] mag2;
  logic signed [WIDE_W-1:0] nr_wide;
  logic signed [WIDE_W-1:0] ni_wide;
  logic                     stop;
  logic                     fin;
  logic [PalW-1:0]          pidx_inc;
  zbeat_t                   beat_q;
  zbeat_t                   beat_d;
  logic [CntW-1:0]          cnt_q;
  logic [CntW-1:0]          cnt_d;
  logic [PalW-1:0]          pidx_q;
  logic [PalW-1:0]          pidx_d;

  assign rr_d = beat_i.zr * beat_i.zr;
  assign ii_d = beat_i.zi * beat_i.zi;
  assign ri_d = beat_i.zr * beat_i.zi;

  // Floor shifts back to Q4.28; the cross term keeps one extra bit for 2*zr*zi.
  assign xx      = WIDE_W'(rr_q >>> 28);
  assign yy      = WIDE_W'(ii_q >>> 28);
  assign xy2     = WIDE_W'(ri_q >>> 27);
  assign mag2    = xx + yy;
  assign nr_wide = xx - yy + WIDE_W'(cre_i);
  assign ni_wide = xy2 + WIDE_W'(cim_i);

  // Escape or limit ends the point; a finished beat keeps its count and palette index.
  assign stop     = (mag2 >= FOUR_Q28) || (a_cnt_q >= CntW'(MAX_ITER));
  assign fin      = a_done_q || stop;
  assign pidx_inc = (a_pidx_q == PalW'(PALETTE_SIZE - 1)) ? '0 : a_pidx_q + PalW'(1);

  always_comb begin
    beat_d.valid = a_valid_q;
    beat_d.done  = fin;
    beat_d.zr    = sat32(nr_wide);
    beat_d.zi    = sat32(ni_wide);
    cnt_d        = fin ? a_cnt_q : a_cnt_q + CntW'(1);
    pidx_d       = fin ? a_pidx_q : pidx_inc;
  end

  // Valid bit of stage A and the whole outgoing beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      beat_q    <= '0;
    end else begin
      a_valid_q <= beat_i.valid;
      beat_q    <= beat_d;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk_i) begin
    a_done_q    <= beat_i.done;
    a_cnt_q     <= cnt_i;
    a_pidx_q    <= pidx_i;
    rr_q        <= rr_d;
    ii_q        <= ii_d;
    ri_q        <= ri_d;
    cnt_q       <= cnt_d;
    pidx_q      <= pidx_d;
  end

  assign beat_o = beat_q;
  assign cnt_o  = cnt_q;
  assign pidx_o = pidx_q;

endmodule

>>> hw/rtl/mandelbrot_escape_time_pixel.sv
// ---------------------------------------------------------------------------
// mandelbrot_escape_time_pixel: escape-time engine, one pixel per command.
// From start to the result strobe, a command passes the mapping registers and the seed
// register, then iterates in the two-cell ring, where an even count passes one idle
// cell on the way out. One pixel at a time: the next start is taken only once busy
// has dropped; results never stall.
// Reset clears control and restores the window to -2.0 .. +2.0; no clearing pass.
// ---------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_macros.svh"

module mandelbrot_escape_time_pixel #(
  parameter int MAX_ITER     = 256,
  parameter int PALETTE_SIZE = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [met_pkg::ADDR_W-1:0]  paddr,
  input  logic [met_pkg::DATA_W-1:0]  pwdata,
  output logic [met_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  // Command and result.
  input  logic                        start,
  output logic                        busy,
  input  met_pkg::pixel_t             pixel_i,
  output logic                        result_valid_o,
  output met_pkg::result_t            result_o
);
  import met_pkg::*;

  localparam int CntW = $clog2(MAX_ITER + 1);
  localparam int PalW = $clog2(PALETTE_SIZE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_RUN
  } state_e;

  // Window registers.
  logic signed [COORD_W-1:0] re_left_q;
  logic signed [COORD_W-1:0] im_top_q;
  logic signed [COORD_W-1:0] re_right_q;
  logic signed [COORD_W-1:0] im_bottom_q;
  logic                      cfg_wr;
  logic [1:0]                cfg_idx;

  // Control and results.
  state_e                    state_q;
  logic                      seed_q;
  logic signed [COORD_W-1:0] cre_q;
  logic signed [COORD_W-1:0] cim_q;
  logic                      res_valid_q;
  result_t                   res_q;
  logic                      accept;
  logic                      re_done;
  logic                      im_done;
  logic                      map_done;
  logic signed [COORD_W-1:0] re_coord;
  logic signed [COORD_W-1:0] im_coord;

  // Ring wiring: slot 0 feeds the first cell, slot k+1 is cell k's output.
  zbeat_t                    ring_beat [NUM_CELLS+1];
  logic [CntW-1:0]           ring_cnt  [NUM_CELLS+1];
  logic [PalW-1:0]           ring_pidx [NUM_CELLS+1];
  logic [NUM_CELLS-1:0]      ring_vld;
  zbeat_t                    head_beat;
  logic [CntW-1:0]           head_cnt;
  logic [PalW-1:0]           head_pidx;
  zbeat_t                    tail_beat;
  logic [CntW-1:0]           tail_cnt;
  logic [PalW-1:0]           tail_pidx;
  logic                      tail_fin;
  logic                      tail_inside;
  logic [NUM_CELLS:0]        live_vld;

  // Register writes complete in the access phase.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_left_q   <= RST_LOW;
      im_top_q    <= RST_LOW;
      re_right_q  <= RST_HIGH;
      im_bottom_q <= RST_HIGH;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RE_LEFT:   re_left_q   <= pwdata;
        REG_IM_TOP:    im_top_q    <= pwdata;
        REG_RE_RIGHT:  re_right_q  <= pwdata;
        REG_IM_BOTTOM: im_bottom_q <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      REG_RE_LEFT:   prdata = re_left_q;
      REG_IM_TOP:    prdata = im_top_q;
      REG_RE_RIGHT:  prdata = re_right_q;
      REG_IM_BOTTOM: prdata = im_bottom_q;
      default:       prdata = '0;
    endcase
  end

  // Map the pixel onto both axes at once.
  assign accept = start && !busy;

  met_map u_map_re (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (accept),
    .lo_i   (re_left_q),
    .hi_i   (re_right_q),
    .pix_i  (pixel_i.pixel_x),
    .done_o (re_done),
    .coord_o(re_coord)
  );

  met_map u_map_im (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (accept),
    .lo_i   (im_top_q),
    .hi_i   (im_bottom_q),
    .pix_i  (pixel_i.pixel_y),
    .done_o (im_done),
    .coord_o(im_coord)
  );

  assign map_done = re_done && im_done;

  // Seed a fresh beat, or recirculate the tail while the point is still live.
  assign tail_beat = ring_beat[NUM_CELLS];
  assign tail_cnt  = ring_cnt[NUM_CELLS];
  assign tail_pidx = ring_pidx[NUM_CELLS];
  assign tail_fin  = tail_beat.valid && tail_beat.done;

  always_comb begin
    if (seed_q) begin
      head_beat.valid = 1'b1;
      head_beat.done  = 1'b0;
      head_beat.zr    = '0;
      head_beat.zi    = '0;
      head_cnt        = '0;
      head_pidx       = '0;
    end else begin
      head_beat.valid = tail_beat.valid && !tail_beat.done;
      head_beat.done  = tail_beat.done;
      head_beat.zr    = tail_beat.zr;
      head_beat.zi    = tail_beat.zi;
      head_cnt        = tail_cnt;
      head_pidx       = tail_pidx;
    end
  end

  assign ring_beat[0] = head_beat;
  assign ring_cnt[0]  = head_cnt;
  assign ring_pidx[0] = head_pidx;

  // The ring of iteration cells.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    met_cell #(
      .MAX_ITER    (MAX_ITER),
      .PALETTE_SIZE(PALETTE_SIZE)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cre_i (cre_q),
      .cim_i (cim_q),
      .beat_i(ring_beat[k]),
      .cnt_i (ring_cnt[k]),
      .pidx_i(ring_pidx[k]),
      .beat_o(ring_beat[k+1]),
      .cnt_o (ring_cnt[k+1]),
      .pidx_o(ring_pidx[k+1])
    );
    assign ring_vld[k] = ring_beat[k+1].valid;
  end

  assign tail_inside = tail_cnt >= CntW'(MAX_ITER);
  assign live_vld    = {seed_q, ring_vld};

  // Sequencer, seed and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      seed_q      <= 1'b0;
      res_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_MAP;
          end
        end
        ST_MAP: begin
          if (map_done) begin
            seed_q  <= 1'b1;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (tail_fin) begin
            res_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Point constants and the result beat.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MAP && map_done) begin
      cre_q <= re_coord;
      cim_q <= im_coord;
    end
    if (state_q == ST_RUN && tail_fin) begin
      res_q.color      <= tail_inside ? INSIDE_COLOR
                                      : {ALPHA_OPAQUE, palette_entry(6'(tail_pidx))};
      res_q.iterations <= 9'(tail_cnt);
      res_q.inside_res <= tail_inside;
    end
  end

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // A result beat lasts one cycle; the next one needs a new command.
  `MET_ASSERT_NEXT(a_strobe_single, result_valid_o, !result_valid_o,
                   "result strobe held for more than one cycle")
  // Only one point circulates in the ring.
  `MET_ASSERT_SAME(a_ring_one_beat, 1'b1, $onehot0(live_vld),
                   "more than one live beat in the cell ring")
  // An accepted command makes the engine busy.
  `MET_ASSERT_NEXT(a_accept_busy, accept, busy, "command accepted but engine not busy")
  // A finished point at the ring tail produces exactly one result.
  `MET_ASSERT_NEXT(a_done_strobe, state_q == ST_RUN && tail_fin,
                   result_valid_o && state_q == ST_IDLE, "finished point gave no result")
  // Points that never escape come out opaque black.
  `MET_ASSERT_SAME(a_inside_black, result_valid_o && result_o.inside_res,
                   result_o.color == INSIDE_COLOR, "inside point with a palette color")

endmodule

>>> tb/sv/tb_mandelbrot_escape_time_pixel.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_mandelbrot_escape_time_pixel: self-checking bench for the pixel engine.
// A directed table sets up reset, extreme, saturating and mirrored windows
// and sends pixels through them. Random phases follow, each with a new
// window, half of them small zooms around the set. Every result beat is
// checked against the table or an escape-time predictor inside the bench.
// ---------------------------------------------------------------------------
module tb_mandelbrot_escape_time_pixel;
  import met_pkg::*;

  localparam longint IMAGE_SIZE  = 512;
  localparam int     MAX_ITER    = 256;
  localparam int     HUE_COUNT   = 64;
  localparam longint Q_ONE       = 64'sd1 << 28;
  localparam longint ESCAPE_R2   = 64'sd4 << 28;
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -64'sd2147483648;
  localparam int     RAND_PHASES = 8;
  localparam int     PHASE_ITEMS = 50;
  localparam int     DRAIN_CYCLES = 600;

  // One period of the sine ramp that feeds the three color channels.
  localparam logic [7:0] HUE_RAMP [64] = '{
    8'd127, 8'd139, 8'd151, 8'd163, 8'd175, 8'd186, 8'd197, 8'd207,
    8'd216, 8'd225, 8'd232, 8'd239, 8'd244, 8'd248, 8'd251, 8'd253,
    8'd254, 8'd253, 8'd251, 8'd248, 8'd244, 8'd239, 8'd232, 8'd225,
    8'd216, 8'd207, 8'd197, 8'd186, 8'd175, 8'd163, 8'd151, 8'd139,
    8'd127, 8'd114, 8'd102, 8'd90,  8'd78,  8'd67,  8'd56,  8'd46,
    8'd37,  8'd28,  8'd21,  8'd14,  8'd9,   8'd5,   8'd2,   8'd0,
    8'd0,   8'd0,   8'd2,   8'd5,   8'd9,   8'd14,  8'd21,  8'd28,
    8'd37,  8'd46,  8'd56,  8'd67,  8'd78,  8'd90,  8'd102, 8'd114
  };

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;

  // A directed row either writes one window register or sends one pixel.
  // Pixel rows with typed set carry their result inline.
  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  cfg_sel;
    logic [31:0] wdata;
    logic [8:0]  px;
    logic [8:0]  py;
    logic        typed;
    result_t     res;
  } directed_row_t;

  localparam int NUM_DIRECTED = 26;
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // Reset window -2.0 .. +2.0.
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd0,   9'd0,   1'b1, '{32'hff8b_e80e, 9'd1, 1'b0}},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd256, 9'd256, 1'b1, '{INSIDE_COLOR, 9'd256, 1'b1}},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd128, 9'd256, 1'b1, '{INSIDE_COLOR, 9'd256, 1'b1}},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd384, 9'd256, 1'b1, '{32'hff97_e109, 9'd2, 1'b0}},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd511, 9'd511, 1'b0, '0},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd511, 9'd0,   1'b0, '0},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd0,   9'd511, 1'b0, '0},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd64,  9'd256, 1'b0, '0},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd300, 9'd150, 1'b0, '0},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd100, 9'd400, 1'b0, '0},
    // Full-range window, imaginary axis mirrored.
    '{ROW_WRITE, REG_RE_LEFT,   32'h8000_0000, 9'd0, 9'd0, 1'b0, '0},
    '{ROW_WRITE, REG_IM_TOP,    32'h7fff_ffff, 9'd0, 9'd0, 1'b0, '0},
    '{ROW_WRITE, REG_RE_RIGHT,  32'h7fff_ffff, 9'd0, 9'd0, 1'b0, '0},
    '{ROW_WRITE, REG_IM_BOTTOM, 32'h8000_0000, 9'd0, 9'd0, 1'b0, '0},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd0,   9'd0,   1'b1, '{32'hff8b_e80e, 9'd1, 1'b0}},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd511, 9'd511, 1'b0, '0},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd256, 9'd256, 1'b0, '0},
    // Both edges at the positive limit: z saturates after one step.
    '{ROW_WRITE, REG_RE_LEFT,   32'h7fff_ffff, 9'd0, 9'd0, 1'b0, '0},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd511, 9'd0,   1'b0, '0},
    // Window mirrored on both axes, +2.0 .. -2.0.
    '{ROW_WRITE, REG_RE_LEFT,   32'h2000_0000, 9'd0, 9'd0, 1'b0, '0},
    '{ROW_WRITE, REG_IM_TOP,    32'h2000_0000, 9'd0, 9'd0, 1'b0, '0},
    '{ROW_WRITE, REG_RE_RIGHT,  32'he000_0000, 9'd0, 9'd0, 1'b0, '0},
    '{ROW_WRITE, REG_IM_BOTTOM, 32'he000_0000, 9'd0, 9'd0, 1'b0, '0},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd0,   9'd0,   1'b1, '{32'hff8b_e80e, 9'd1, 1'b0}},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd384, 9'd256, 1'b1, '{INSIDE_COLOR, 9'd256, 1'b1}},
    '{ROW_PIXEL, REG_RE_LEFT, 32'h0, 9'd77,  9'd430, 1'b0, '0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                start;
  logic                busy;
  pixel_t              pixel_i;
  logic                result_valid_o;
  result_t             result_o;

  // Window as the engine should hold it.
  logic signed [31:0]  win_re_left;
  logic signed [31:0]  win_im_top;
  logic signed [31:0]  win_re_right;
  logic signed [31:0]  win_im_bottom;

  result_t             results_due[$];
  int unsigned         mismatch_count = 0;

  mandelbrot_escape_time_pixel u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .pixel_i        (pixel_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Saturate a wide value into the signed 32-bit Q4.28 range.
  function automatic longint clamp_q28(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // Linear map of a pixel index onto one window axis, floored.
  function automatic longint map_axis(input longint lo, input longint hi,
                                      input logic [8:0] pix);
    longint num;
    longint q;
    num = (hi - lo) * longint'(pix);
    if (num >= 0) q = num / IMAGE_SIZE;
    else q = -((-num + IMAGE_SIZE - 1) / IMAGE_SIZE);
    return clamp_q28(lo + q);
  endfunction

  // Escape-time count and color of one pixel under the current window.
  function automatic result_t escape_time(input pixel_t p);
    longint      c_re;
    longint      c_im;
    longint      zr;
    longint      zi;
    longint      xx;
    longint      yy;
    longint      nr;
    int unsigned n;
    logic [5:0]  k;
    result_t     r;
    c_re = map_axis(longint'(win_re_left), longint'(win_re_right), p.pixel_x);
    c_im = map_axis(longint'(win_im_top), longint'(win_im_bottom), p.pixel_y);
    zr = 0;
    zi = 0;
    n = 0;
    while (1) begin
      xx = (zr * zr) >>> 28;
      yy = (zi * zi) >>> 28;
      if (!(xx + yy < ESCAPE_R2) || n >= MAX_ITER) break;
      n++;
      nr = clamp_q28(xx - yy + c_re);
      zi = clamp_q28(((zr * zi) >>> 27) + c_im);
      zr = nr;
    end
    r.iterations = n[8:0];
    r.inside_res = (n >= MAX_ITER);
    if (r.inside_res) begin
      r.color = INSIDE_COLOR;
    end else begin
      k = 6'(n % HUE_COUNT);
      r.color = {ALPHA_OPAQUE, HUE_RAMP[k], HUE_RAMP[6'(k + 6'd21)], HUE_RAMP[6'(k + 6'd42)]};
    end
    return r;
  endfunction

  // One APB transfer, setup then access, then back to idle; called at a
  // falling edge and returns at one.
  task automatic apb_transfer(input logic wr, input logic [1:0] sel,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_readback(input logic [1:0] sel, input logic [31:0] want);
    logic [31:0] got;
    apb_transfer(1'b0, sel, '0, got);
    if (got !== want) begin
      $display("%0t: register %0d readback expected %h actual %h", $time, sel, want, got);
      mismatch_count++;
    end
  endtask

  // Write one window register, track it in the predictor, read it back.
  task automatic write_window(input logic [1:0] sel, input logic [31:0] value);
    logic [31:0] unused;
    apb_transfer(1'b1, sel, value, unused);
    case (sel)
      REG_RE_LEFT:   win_re_left   = value;
      REG_IM_TOP:    win_im_top    = value;
      REG_RE_RIGHT:  win_re_right  = value;
      REG_IM_BOTTOM: win_im_bottom = value;
      default: ;
    endcase
    check_readback(sel, value);
  endtask

  // Hand one pixel to the engine; start stays high after the beat so that
  // a back-to-back pixel needs no second assignment in the same step.
  task automatic send_pixel(input pixel_t p, input int gap, input result_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start   <= 1'b1;
    pixel_i <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    results_due.push_back(want);
    @(negedge clk_i);
  endtask

  // Drop start and wait until every pending result has come back.
  task automatic settle();
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Pick a new window: half the time a small zoom around the set, else the
  // overview, raw noise or the numeric limits, and sometimes mirrored.
  task automatic retarget_window();
    longint cr;
    longint ci;
    longint hs;
    longint left;
    longint right;
    longint top;
    longint bottom;
    longint tmp;
    int     mode;
    longint corners [4];
    corners = '{Q_MIN, Q_MAX, 0, -1};
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      cr = longint'($urandom_range(0, 40960)) * (64'sd1 << 14) - 2 * Q_ONE;
      ci = longint'($urandom_range(0, 40960)) * (64'sd1 << 14) - 64'sd335544320;
      hs = (mode == 5) ? 2 * Q_ONE : (Q_ONE >>> $urandom_range(1, 14));
      left   = cr - hs;
      right  = cr + hs;
      top    = ci - hs;
      bottom = ci + hs;
    end else if (mode <= 7) begin
      left   = longint'(signed'($urandom));
      right  = longint'(signed'($urandom));
      top    = longint'(signed'($urandom));
      bottom = longint'(signed'($urandom));
    end else begin
      left   = corners[$urandom_range(0, 3)];
      right  = corners[$urandom_range(0, 3)];
      top    = corners[$urandom_range(0, 3)];
      bottom = corners[$urandom_range(0, 3)];
    end
    if ($urandom_range(0, 3) == 0) begin
      tmp = left;
      left = right;
      right = tmp;
    end
    if ($urandom_range(0, 3) == 0) begin
      tmp = top;
      top = bottom;
      bottom = tmp;
    end
    write_window(REG_RE_LEFT,   32'(clamp_q28(left)));
    write_window(REG_IM_TOP,    32'(clamp_q28(top)));
    write_window(REG_RE_RIGHT,  32'(clamp_q28(right)));
    write_window(REG_IM_BOTTOM, 32'(clamp_q28(bottom)));
  endtask

  // Compare each result beat with the oldest pending expectation.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (results_due.size() == 0) begin
        $display("%0t: result with none pending, expected none actual %h", $time, result_o);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        if (result_o.color !== want.color) begin
          $display("%0t: color expected %h actual %h", $time, want.color, result_o.color);
          mismatch_count++;
        end
        if (result_o.iterations !== want.iterations) begin
          $display("%0t: iterations expected %0d actual %0d", $time,
                   want.iterations, result_o.iterations);
          mismatch_count++;
        end
        if (result_o.inside_res !== want.inside_res) begin
          $display("%0t: inside_res expected %b actual %b", $time,
                   want.inside_res, result_o.inside_res);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    directed_row_t row;
    pixel_t        pix;
    int            gap;
    bit            steady;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    start   = 1'b0;
    pixel_i = '0;
    win_re_left   = RST_LOW;
    win_im_top    = RST_LOW;
    win_re_right  = RST_HIGH;
    win_im_bottom = RST_HIGH;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The reset window must read back before anything is written.
    check_readback(REG_RE_LEFT,   RST_LOW);
    check_readback(REG_IM_TOP,    RST_LOW);
    check_readback(REG_RE_RIGHT,  RST_HIGH);
    check_readback(REG_IM_BOTTOM, RST_HIGH);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_window(row.cfg_sel, row.wdata);
      end else begin
        pix.pixel_x = row.px;
        pix.pixel_y = row.py;
        send_pixel(pix, $urandom_range(0, 6), row.typed ? row.res : escape_time(pix));
      end
    end

    // Random phases, each under a fresh window; every phase starts idle.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      retarget_window();
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 7) == 0) begin
          pix.pixel_x = $urandom_range(0, 1) ? 9'd511 : 9'd0;
          pix.pixel_y = $urandom_range(0, 1) ? 9'd511 : 9'd0;
        end else begin
          pix = pixel_t'(18'($urandom));
        end
        gap = steady ? 0 : $urandom_range(0, 6);
        send_pixel(pix, gap, escape_time(pix));
      end
    end

    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #15_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/met_pkg.sv
hw/rtl/met_map.sv
hw/rtl/met_cell.sv
hw/rtl/mandelbrot_escape_time_pixel.sv
tb/sv/tb_mandelbrot_escape_time_pixel.sv
